// ===== rtl/banded_local_alignment_score_unit_defines.svh =====
// Assertion macros for the banded local alignment score unit.
// Used by the top level; the clock and reset names clk and arst_n are taken from the caller.
`ifndef BANDED_LOCAL_ALIGNMENT_SCORE_UNIT_DEFINES_SVH
`define BANDED_LOCAL_ALIGNMENT_SCORE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define BLAS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define BLAS_ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define BLAS_ASSERT(lbl, prop, msg)
`define BLAS_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

// ===== rtl/blas_pkg.sv =====
// Types and constants shared by the banded local alignment score unit.
// No dependencies.
`timescale 1ns / 1ps
package blas_pkg;
	localparam int SCORE_W = 14;
	localparam int WIDE_W  = SCORE_W + 2;
	localparam int BASE_W  = 8;
	localparam int BAND_W  = 7;
	localparam int CIDX_W  = 2;
	localparam int CDAT_W  = 7;

	typedef logic [SCORE_W-1:0]        score_t;
	typedef logic signed [WIDE_W-1:0]  wide_t;
	typedef logic [BASE_W-1:0]         base_t;

	typedef struct packed {
		logic [3:0]        match_gain;
		logic signed [4:0] mismatch_penalty;
		logic signed [4:0] gap_penalty;
	} cfg_t;

	localparam score_t SCORE_TOP = '1;
	localparam wide_t  WIDE_TOP  = {2'b00, SCORE_TOP};

	localparam logic [CIDX_W-1:0] REG_BAND     = 2'd0;
	localparam logic [CIDX_W-1:0] REG_MATCH    = 2'd1;
	localparam logic [CIDX_W-1:0] REG_MISMATCH = 2'd2;
	localparam logic [CIDX_W-1:0] REG_GAP      = 2'd3;

	localparam logic [BAND_W-1:0] BAND_RST     = 7'd8;
	localparam logic [3:0]        MATCH_RST    = 4'd1;
	localparam logic [4:0]        MISMATCH_RST = 5'b11110;
	localparam logic [4:0]        GAP_RST      = 5'b11101;
endpackage

// ===== rtl/blas_ref_mem.sv =====
// Reference base store: one write port, one registered read port.
// Depends on blas_pkg.
`timescale 1ns / 1ps
module blas_ref_mem #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic            clk,
	input  logic            wr_en,
	input  logic [AW-1:0]   wr_addr,
	input  blas_pkg::base_t wr_data,
	input  logic [AW-1:0]   rd_addr,
	output blas_pkg::base_t rd_data
);
	import blas_pkg::*;

	base_t mem [DEPTH];
	base_t rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	assign rd_data = rd_q;
endmodule

// ===== rtl/blas_row_store.sv =====
// Row score store with per-entry valid bits; an invalid entry reads as zero.
// Depends on blas_pkg.
`timescale 1ns / 1ps
module blas_row_store #(
	parameter int DEPTH = 66,
	parameter int AW    = 7
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [AW-1:0]    rd_addr,
	output blas_pkg::score_t rd_data,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  blas_pkg::score_t wr_data,
	input  logic             inv_en,
	input  logic [AW-1:0]    inv_addr,
	input  logic             clr_all
);
	import blas_pkg::*;

	score_t           mem [DEPTH];
	score_t           rd_q;
	logic [DEPTH-1:0] vld_q;
	logic             rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			rd_vld_q <= vld_q[rd_addr];
			if (clr_all) begin
				vld_q <= '0;
			end else begin
				if (wr_en) begin
					vld_q[wr_addr] <= 1'b1;
				end
				if (inv_en) begin
					vld_q[inv_addr] <= 1'b0;
				end
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_q : '0;
endmodule

// ===== rtl/blas_cell.sv =====
// One alignment cell: best of diagonal, up, left and zero, saturated at the top score.
// Depends on blas_pkg.
`timescale 1ns / 1ps
module blas_cell (
	input  blas_pkg::cfg_t   cfg,
	input  blas_pkg::score_t diag,
	input  blas_pkg::score_t up,
	input  blas_pkg::score_t left,
	input  logic             eq,
	output blas_pkg::score_t score
);
	import blas_pkg::*;

	wide_t mat_x, mis_x, gap_x;
	wide_t d_sum, u_sum, l_sum, m1, m2;

	always_comb begin
		mat_x = $signed({{(WIDE_W-4){1'b0}}, cfg.match_gain});
		mis_x = $signed({{(WIDE_W-5){cfg.mismatch_penalty[4]}}, cfg.mismatch_penalty});
		gap_x = $signed({{(WIDE_W-5){cfg.gap_penalty[4]}}, cfg.gap_penalty});
		d_sum = $signed({2'b00, diag}) + (eq ? mat_x : mis_x);
		u_sum = $signed({2'b00, up}) + gap_x;
		l_sum = $signed({2'b00, left}) + gap_x;
		m1    = (d_sum > u_sum) ? d_sum : u_sum;
		m2    = (m1 < l_sum) ? l_sum : m1;
		if (m2[WIDE_W-1]) begin
			score = '0;
		end else if (m2 > WIDE_TOP) begin
			score = SCORE_TOP;
		end else begin
			score = m2[SCORE_W-1:0];
		end
	end
endmodule

// ===== rtl/banded_local_alignment_score_unit.sv =====
// Channel   Signals                          Direction
// in        in_valid in_ready req_type base last   item in
// out       out_valid out_ready best_score   item out
// cfg       cfg_valid cfg_ready cfg_index cfg_data register write
//
// A reference item is stored on acceptance while the store has room, and in_ready stays
// high. A query item, b being the band limited to MAX_BAND, walks the row store one cell
// per cycle behind its registered read, then closes the row in S_FIN. Reset clears all
// control state and the row valid bits at once. The result waits in an output register;
// a final row waits in S_FIN only if an earlier result has not been taken.
// Top level of the banded local alignment score unit.
// Depends on blas_pkg, blas_ref_mem, blas_row_store, blas_cell and the defines header.
`timescale 1ns / 1ps
`include "banded_local_alignment_score_unit_defines.svh"
module banded_local_alignment_score_unit #(
	parameter int MAX_BAND = 64,
	parameter int MAX_LEN  = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          req_type,
	input  blas_pkg::base_t               base,
	input  logic                          last,
	output logic                          out_valid,
	input  logic                          out_ready,
	output blas_pkg::score_t              best_score,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [blas_pkg::CIDX_W-1:0]   cfg_index,
	input  logic [blas_pkg::CDAT_W-1:0]   cfg_data
);
	import blas_pkg::*;

	localparam int LEN_W = $clog2(MAX_LEN);
	localparam int CNT_W = $clog2(MAX_LEN + 1);
	localparam int IDX_W = $clog2(MAX_BAND + 2);
	localparam int POS_W = $clog2(MAX_LEN + MAX_BAND + 1);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_ROW  = 3'b010,
		S_FIN  = 3'b100
	} state_t;

	state_t             state_q;
	logic [BAND_W-1:0]  band_q;
	cfg_t               cfg_q;
	logic [CNT_W-1:0]   ref_cnt_q, row_num_q;
	score_t             best_q, diag_q, left_q, out_score_q;
	base_t              qbase_q;
	logic               last_q, issue_done_q, eq_q, out_valid_q;
	logic [IDX_W-1:0]   b_q, k_q;
	logic               arr_s1, lt_s1;
	logic [IDX_W-1:0]   k_s1;

	logic               in_acc, issue, compute, row_end, fin_go;
	logic [IDX_W-1:0]   b_nxt;
	logic [POS_W-1:0]   pos;
	logic               lt, eq_now, ref_wr;
	base_t              ref_rd;
	score_t             row_rd, cell_s;

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign best_score = out_score_q;

	assign b_nxt   = (32'(band_q) > MAX_BAND) ? IDX_W'(MAX_BAND) : IDX_W'(band_q);
	assign issue   = (state_q == S_ROW) && !issue_done_q;
	assign pos     = POS_W'(row_num_q) + POS_W'(k_q) - POS_W'(1);
	assign lt      = pos < POS_W'(ref_cnt_q);
	assign ref_wr  = in_acc && !req_type && (ref_cnt_q < CNT_W'(MAX_LEN));
	assign eq_now  = lt_s1 && (ref_rd == qbase_q);
	assign compute = arr_s1 && (k_s1 != IDX_W'(1));
	assign row_end = arr_s1 && (k_s1 == b_q + IDX_W'(1));
	assign fin_go  = (state_q == S_FIN) && !(last_q && out_valid_q && !out_ready);

	blas_ref_mem #(.DEPTH(MAX_LEN), .AW(LEN_W)) u_ref (
		.clk     (clk),
		.wr_en   (ref_wr),
		.wr_addr (ref_cnt_q[LEN_W-1:0]),
		.wr_data (base),
		.rd_addr (pos[LEN_W-1:0]),
		.rd_data (ref_rd)
	);

	blas_row_store #(.DEPTH(MAX_BAND + 2), .AW(IDX_W)) u_row (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_addr  (k_q),
		.rd_data  (row_rd),
		.wr_en    (compute),
		.wr_addr  (k_s1 - IDX_W'(1)),
		.wr_data  (cell_s),
		.inv_en   (fin_go),
		.inv_addr (b_q + IDX_W'(1)),
		.clr_all  (fin_go && last_q)
	);

	blas_cell u_cell (
		.cfg   (cfg_q),
		.diag  (diag_q),
		.up    (row_rd),
		.left  (left_q),
		.eq    (eq_q),
		.score (cell_s)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_q                 <= BAND_RST;
			cfg_q.match_gain       <= MATCH_RST;
			cfg_q.mismatch_penalty <= MISMATCH_RST;
			cfg_q.gap_penalty      <= GAP_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_BAND:     band_q                 <= cfg_data;
				REG_MATCH:    cfg_q.match_gain       <= cfg_data[3:0];
				REG_MISMATCH: cfg_q.mismatch_penalty <= cfg_data[4:0];
				REG_GAP:      cfg_q.gap_penalty      <= cfg_data[4:0];
				default:      ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			ref_cnt_q    <= '0;
			row_num_q    <= '0;
			best_q       <= '0;
			issue_done_q <= 1'b0;
			arr_s1       <= 1'b0;
			out_valid_q  <= 1'b0;
			k_q          <= '0;
		end else begin
			arr_s1 <= issue;
			if (fin_go && last_q) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (ref_wr) begin
						ref_cnt_q <= ref_cnt_q + CNT_W'(1);
					end
					if (in_acc && req_type) begin
						state_q      <= S_ROW;
						k_q          <= IDX_W'(1);
						issue_done_q <= 1'b0;
					end
				end
				S_ROW: begin
					if (issue) begin
						k_q <= k_q + IDX_W'(1);
						if (k_q == b_q + IDX_W'(1)) begin
							issue_done_q <= 1'b1;
						end
					end
					if (compute && (cell_s > best_q)) begin
						best_q <= cell_s;
					end
					if (row_end) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (fin_go) begin
						state_q <= S_IDLE;
						if (last_q) begin
							ref_cnt_q <= '0;
							row_num_q <= '0;
							best_q    <= '0;
						end else if (row_num_q < CNT_W'(MAX_LEN)) begin
							row_num_q <= row_num_q + CNT_W'(1);
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && req_type) begin
			qbase_q <= base;
			last_q  <= last;
			b_q     <= b_nxt;
			left_q  <= '0;
		end
		k_s1  <= k_q;
		lt_s1 <= lt;
		if (arr_s1) begin
			diag_q <= row_rd;
			eq_q   <= eq_now;
		end
		if (compute) begin
			left_q <= cell_s;
		end
		if (fin_go && last_q) begin
			out_score_q <= best_q;
		end
	end

	`BLAS_ASSERT_NEVER(a_row_rw_clash,
		compute && issue && (k_q == k_s1 - IDX_W'(1)),
		"row store read and write hit the same entry")
	`BLAS_ASSERT(a_row_end_fin,
		(state_q == S_ROW) && row_end |=> state_q == S_FIN,
		"row did not close after its last cell")
	`BLAS_ASSERT(a_last_emits,
		fin_go && last_q |=> out_valid_q && (best_q == '0) && (ref_cnt_q == '0),
		"final row did not emit and clear")
endmodule
